### hw/rtl/pscc_pkg.sv
// Shared types, codes and the sequencer program of the secant code calibrator.
`default_nettype none

package pscc_pkg;

  // Command codes of an input beat.
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_COUNT = 2'd1,
    CMD_ABORT = 2'd2
  } cmd_e;

  // Configuration register indexes.
  localparam logic [1:0] REG_TARGET    = 2'd0;
  localparam logic [1:0] REG_TOLERANCE = 2'd1;
  localparam logic [1:0] REG_GAIN      = 2'd2;
  localparam logic [1:0] REG_MAX_STEPS = 2'd3;

  localparam logic [15:0] TargetReset = 16'd0;
  localparam logic [7:0]  TolReset    = 8'd1;
  localparam logic [3:0]  GainReset   = 4'd5;
  localparam logic [7:0]  MaxReset    = 8'd2;

  localparam int CfgW   = 16;
  localparam int CntW   = 16;
  localparam int ErrW   = 17;
  localparam int CorrW  = 32;
  localparam int ProdW  = ErrW + CorrW;
  localparam int NumW   = ProdW - 1;
  localparam int DcntW  = $clog2(NumW);
  localparam int DacW   = 11;
  localparam int StartW = 11;

  // Datapath operations, one per control word.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_ERR,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_FIN,
    OP_CORR_SHIFT,
    OP_CORR_FLAT,
    OP_CODE_ADD,
    OP_APPLY,
    OP_STEP_INC,
    OP_SET_FIRST,
    OP_FIN_OK,
    OP_FIN_FAIL,
    OP_START,
    OP_EMIT
  } ucop_e;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_ITEM,
    C_IS_START,
    C_NOT_COUNT_RUN,
    C_NOT_ABORT_RUN,
    C_HIT,
    C_FIRST_FORM,
    C_DIFF_ZERO,
    C_DIV_MORE,
    C_BOUND_FAIL,
    C_NOT_REACHED,
    C_STEP_ZERO,
    C_OUT_BUSY
  } ucond_e;

  localparam int StepW = 5;

  localparam logic [StepW-1:0] A_WAIT    = 5'd0;
  localparam logic [StepW-1:0] A_DIV     = 5'd9;
  localparam logic [StepW-1:0] A_FIRST   = 5'd11;
  localparam logic [StepW-1:0] A_FLAT    = 5'd12;
  localparam logic [StepW-1:0] A_ADVANCE = 5'd16;
  localparam logic [StepW-1:0] A_HIT     = 5'd19;
  localparam logic [StepW-1:0] A_HIT0    = 5'd21;
  localparam logic [StepW-1:0] A_FAIL    = 5'd22;
  localparam logic [StepW-1:0] A_START   = 5'd23;
  localparam logic [StepW-1:0] A_ABORT   = 5'd24;
  localparam logic [StepW-1:0] A_EMIT    = 5'd26;

  typedef struct packed {
    ucop_e            op;
    ucond_e           cond;
    logic [StepW-1:0] tgt;
  } ctl_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic no_item;
    logic is_start;
    logic count_run;
    logic abort_run;
    logic hit;
    logic first_form;
    logic diff_zero;
    logic div_more;
    logic bound_fail;
    logic reached;
    logic step_zero;
    logic out_busy;
  } flags_t;

  // Microprogram: jump to tgt when cond holds, else advance.
  function automatic ctl_t prog_rom(input logic [StepW-1:0] addr);
    ctl_t w;
    case (addr)
      5'd0:  w = '{OP_LATCH,      C_NO_ITEM,       A_WAIT};
      5'd1:  w = '{OP_NOP,        C_IS_START,      A_START};
      5'd2:  w = '{OP_NOP,        C_NOT_COUNT_RUN, A_ABORT};
      5'd3:  w = '{OP_ERR,        C_NONE,          A_WAIT};
      5'd4:  w = '{OP_NOP,        C_HIT,           A_HIT};
      5'd5:  w = '{OP_NOP,        C_FIRST_FORM,    A_FIRST};
      5'd6:  w = '{OP_NOP,        C_DIFF_ZERO,     A_FLAT};
      5'd7:  w = '{OP_MUL,        C_NONE,          A_WAIT};
      5'd8:  w = '{OP_DIV_INIT,   C_NONE,          A_WAIT};
      5'd9:  w = '{OP_DIV_STEP,   C_DIV_MORE,      A_DIV};
      5'd10: w = '{OP_DIV_FIN,    C_ALWAYS,        5'd13};
      5'd11: w = '{OP_CORR_SHIFT, C_ALWAYS,        5'd13};
      5'd12: w = '{OP_CORR_FLAT,  C_NONE,          A_WAIT};
      5'd13: w = '{OP_CODE_ADD,   C_NONE,          A_WAIT};
      5'd14: w = '{OP_NOP,        C_BOUND_FAIL,    A_FAIL};
      5'd15: w = '{OP_APPLY,      C_NONE,          A_WAIT};
      5'd16: w = '{OP_STEP_INC,   C_NONE,          A_WAIT};
      5'd17: w = '{OP_NOP,        C_NOT_REACHED,   A_EMIT};
      5'd18: w = '{OP_FIN_OK,     C_ALWAYS,        A_EMIT};
      5'd19: w = '{OP_NOP,        C_STEP_ZERO,     A_HIT0};
      5'd20: w = '{OP_FIN_OK,     C_ALWAYS,        A_EMIT};
      5'd21: w = '{OP_SET_FIRST,  C_ALWAYS,        A_ADVANCE};
      5'd22: w = '{OP_FIN_FAIL,   C_ALWAYS,        A_EMIT};
      5'd23: w = '{OP_START,      C_ALWAYS,        A_EMIT};
      5'd24: w = '{OP_NOP,        C_NOT_ABORT_RUN, A_EMIT};
      5'd25: w = '{OP_FIN_FAIL,   C_NONE,          A_WAIT};
      5'd26: w = '{OP_EMIT,       C_OUT_BUSY,      A_EMIT};
      5'd27: w = '{OP_NOP,        C_ALWAYS,        A_WAIT};
      default: w = '{OP_NOP,      C_ALWAYS,        A_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/pscc_useq.sv
// Step counter, program table and jump logic of the calibrator sequencer.
`default_nettype none

module pscc_useq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  pscc_pkg::flags_t     flags_i,
  output pscc_pkg::ucop_e      op_o
);

  logic [pscc_pkg::StepW-1:0] upc_q, upc_d;
  pscc_pkg::ctl_t             ctl;
  logic                       take;

  always_comb begin
    ctl = pscc_pkg::prog_rom(upc_q);
    case (ctl.cond)
      pscc_pkg::C_NONE:          take = 1'b0;
      pscc_pkg::C_ALWAYS:        take = 1'b1;
      pscc_pkg::C_NO_ITEM:       take = flags_i.no_item;
      pscc_pkg::C_IS_START:      take = flags_i.is_start;
      pscc_pkg::C_NOT_COUNT_RUN: take = !flags_i.count_run;
      pscc_pkg::C_NOT_ABORT_RUN: take = !flags_i.abort_run;
      pscc_pkg::C_HIT:           take = flags_i.hit;
      pscc_pkg::C_FIRST_FORM:    take = flags_i.first_form;
      pscc_pkg::C_DIFF_ZERO:     take = flags_i.diff_zero;
      pscc_pkg::C_DIV_MORE:      take = flags_i.div_more;
      pscc_pkg::C_BOUND_FAIL:    take = flags_i.bound_fail;
      pscc_pkg::C_NOT_REACHED:   take = !flags_i.reached;
      pscc_pkg::C_STEP_ZERO:     take = flags_i.step_zero;
      pscc_pkg::C_OUT_BUSY:      take = flags_i.out_busy;
      default:                   take = 1'b0;
    endcase
    upc_d = take ? ctl.tgt : upc_q + 1'b1;
    op_o  = ctl.op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= pscc_pkg::A_WAIT;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pscc_datapath.sv
// Datapath of the calibrator: config, loop state, multiplier, serial divider, output register.
`default_nettype none

module pscc_datapath #(
  parameter int CODE_MAX = 2047
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  pscc_pkg::ucop_e                    op_i,
  output pscc_pkg::flags_t                   flags_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [pscc_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    command_i,
  input  wire logic [pscc_pkg::StartW-1:0]   start_code_i,
  input  wire logic [pscc_pkg::CntW-1:0]     count_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [pscc_pkg::DacW-1:0]          dac_code_o,
  output logic                               apply_o,
  output logic                               done_res_o,
  output logic                               pass_o
);

  localparam int CodeLog = $clog2(CODE_MAX + 1);
  localparam int CodeW   = (CodeLog > pscc_pkg::DacW) ? CodeLog : pscc_pkg::DacW;
  localparam int SumW    = pscc_pkg::CorrW + 2;
  localparam int ErrW    = pscc_pkg::ErrW;
  localparam int CorrW   = pscc_pkg::CorrW;
  localparam int ProdW   = pscc_pkg::ProdW;
  localparam int NumW    = pscc_pkg::NumW;
  localparam int CntW    = pscc_pkg::CntW;
  localparam int DcntW   = pscc_pkg::DcntW;

  localparam logic [CodeW-1:0]       CodeMax   = CodeW'(CODE_MAX);
  localparam logic signed [SumW-1:0] CodeMaxS  = SumW'(CODE_MAX);
  localparam logic [DcntW-1:0]       DcntLast  = DcntW'(NumW - 1);
  localparam logic signed [ProdW-1:0] SatMax   = ProdW'(64'sh7FFFFFFF);
  localparam logic signed [ProdW-1:0] SatMin   = -ProdW'(64'sh80000000);

  // configuration
  logic [15:0] target_q;
  logic [7:0]  tol_q;
  logic [3:0]  gain_q;
  logic [7:0]  max_q;

  // loop state
  logic [CodeW-1:0]        fine_q;
  logic [CntW-1:0]         prev_q;
  logic signed [CorrW-1:0] last_corr_q;
  logic [7:0]              step_q;
  logic                    first_q;
  logic                    run_q;
  logic                    pass_q;
  logic                    apply_q;
  logic [DcntW-1:0]        dcnt_q;

  // working registers
  logic [1:0]              cmd_q;
  logic [pscc_pkg::StartW-1:0] start_q;
  logic [CntW-1:0]         cnt_q;
  logic signed [ErrW-1:0]  err_q;
  logic signed [ProdW-1:0] prod_q;
  logic [NumW-1:0]         num_q;
  logic [CntW-1:0]         rem_q;
  logic [CntW-1:0]         dsr_q;
  logic                    neg_q;
  logic signed [CorrW-1:0] corr_q;

  logic                    accept;
  logic                    emit;
  logic signed [ErrW-1:0]  err_d;
  logic signed [ErrW-1:0]  diff;
  logic [ErrW-1:0]         err_mag;
  logic [ErrW-1:0]         diff_mag;
  logic [ProdW-1:0]        prod_mag;
  logic [CntW:0]           rem_sh;
  logic                    qbit;
  logic [CntW:0]           rem_sub;
  logic signed [ProdW-1:0] quot_s;
  logic signed [CorrW-1:0] corr_div;
  logic signed [CorrW-1:0] err_ext;
  logic signed [SumW-1:0]  sum;
  logic [CodeW-1:0]        code_d;
  logic [CodeW-1:0]        start_ext;

  always_comb begin
    accept     = (op_i == pscc_pkg::OP_LATCH) && in_valid_i;
    in_stall_o = (op_i != pscc_pkg::OP_LATCH);
    emit       = (op_i == pscc_pkg::OP_EMIT) && !(out_valid_o && out_stall_i);

    err_d    = $signed({1'b0, target_q}) - $signed({1'b0, cnt_q});
    diff     = $signed({1'b0, cnt_q}) - $signed({1'b0, prev_q});
    err_mag  = err_q[ErrW-1] ? ErrW'(-err_q) : ErrW'(err_q);
    diff_mag = diff[ErrW-1] ? ErrW'(-diff) : ErrW'(diff);
    prod_mag = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);
    err_ext  = CorrW'(err_q);

    rem_sh  = {rem_q, num_q[NumW-1]};
    qbit    = rem_sh >= {1'b0, dsr_q};
    rem_sub = qbit ? rem_sh - {1'b0, dsr_q} : rem_sh;

    quot_s = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
    if (quot_s > SatMax) begin
      corr_div = CorrW'(SatMax);
    end else if (quot_s < SatMin) begin
      corr_div = CorrW'(SatMin);
    end else begin
      corr_div = quot_s[CorrW-1:0];
    end

    sum = $signed({{(SumW-CodeW){1'b0}}, fine_q}) +
          $signed({{(SumW-CorrW){corr_q[CorrW-1]}}, corr_q});
    if (sum >= CodeMaxS) begin
      code_d = CodeMax;
    end else if (sum <= 0) begin
      code_d = '0;
    end else begin
      code_d = sum[CodeW-1:0];
    end

    start_ext = CodeW'(start_q);

    flags_o.no_item    = !in_valid_i;
    flags_o.is_start   = (cmd_q == pscc_pkg::CMD_START);
    flags_o.count_run  = (cmd_q == pscc_pkg::CMD_COUNT) && run_q;
    flags_o.abort_run  = (cmd_q == pscc_pkg::CMD_ABORT) && run_q;
    flags_o.hit        = err_mag <= ErrW'(tol_q);
    flags_o.first_form = (step_q == '0) || first_q;
    flags_o.diff_zero  = (cnt_q == prev_q);
    flags_o.div_more   = (dcnt_q != DcntLast);
    flags_o.bound_fail = ((fine_q == CodeMax) || (fine_q == '0)) && (step_q != '0);
    flags_o.reached    = (step_q >= max_q) || (step_q == '0);
    flags_o.step_zero  = (step_q == '0);
    flags_o.out_busy   = out_valid_o && out_stall_i;
  end

  // payload, working and output data registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= command_i;
      start_q <= start_code_i;
      cnt_q   <= count_i;
    end
    case (op_i)
      pscc_pkg::OP_ERR: begin
        err_q <= err_d;
      end
      pscc_pkg::OP_MUL: begin
        prod_q <= ProdW'(err_q) * ProdW'(last_corr_q);
      end
      pscc_pkg::OP_DIV_INIT: begin
        num_q <= prod_mag[NumW-1:0];
        rem_q <= '0;
        dsr_q <= diff_mag[CntW-1:0];
        neg_q <= prod_q[ProdW-1] ^ diff[ErrW-1];
      end
      pscc_pkg::OP_DIV_STEP: begin
        num_q <= {num_q[NumW-2:0], qbit};
        rem_q <= rem_sub[CntW-1:0];
      end
      pscc_pkg::OP_DIV_FIN: begin
        corr_q <= corr_div;
      end
      pscc_pkg::OP_CORR_SHIFT: begin
        corr_q <= err_ext <<< gain_q;
      end
      pscc_pkg::OP_CORR_FLAT: begin
        corr_q <= (err_ext <<< 4) + (err_ext <<< 2);
      end
      default: begin
      end
    endcase
    if (emit) begin
      dac_code_o <= fine_q[pscc_pkg::DacW-1:0];
      apply_o    <= apply_q;
      done_res_o <= !run_q;
      pass_o     <= pass_q;
    end
  end

  // config, loop state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= pscc_pkg::TargetReset;
      tol_q       <= pscc_pkg::TolReset;
      gain_q      <= pscc_pkg::GainReset;
      max_q       <= pscc_pkg::MaxReset;
      fine_q      <= '0;
      prev_q      <= '0;
      last_corr_q <= '0;
      step_q      <= '0;
      first_q     <= 1'b0;
      run_q       <= 1'b0;
      pass_q      <= 1'b1;
      apply_q     <= 1'b0;
      dcnt_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pscc_pkg::REG_TARGET:    target_q <= cfg_data_i;
          pscc_pkg::REG_TOLERANCE: tol_q    <= cfg_data_i[7:0];
          pscc_pkg::REG_GAIN:      gain_q   <= cfg_data_i[3:0];
          pscc_pkg::REG_MAX_STEPS: max_q    <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        apply_q <= 1'b0;
      end
      case (op_i)
        pscc_pkg::OP_DIV_INIT: dcnt_q <= '0;
        pscc_pkg::OP_DIV_STEP: dcnt_q <= dcnt_q + 1'b1;
        pscc_pkg::OP_CORR_SHIFT: first_q <= 1'b0;
        pscc_pkg::OP_CODE_ADD: begin
          last_corr_q <= corr_q;
          fine_q      <= code_d;
        end
        pscc_pkg::OP_APPLY: begin
          prev_q  <= cnt_q;
          apply_q <= 1'b1;
        end
        pscc_pkg::OP_STEP_INC: step_q <= step_q + 1'b1;
        pscc_pkg::OP_SET_FIRST: first_q <= 1'b1;
        pscc_pkg::OP_FIN_OK: run_q <= 1'b0;
        pscc_pkg::OP_FIN_FAIL: begin
          run_q  <= 1'b0;
          pass_q <= 1'b0;
        end
        pscc_pkg::OP_START: begin
          fine_q      <= (start_ext > CodeMax) ? CodeMax : start_ext;
          prev_q      <= '0;
          last_corr_q <= '0;
          step_q      <= '0;
          first_q     <= 1'b0;
          run_q       <= 1'b1;
          pass_q      <= 1'b1;
          apply_q     <= 1'b1;
        end
        default: begin
        end
      endcase
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pll_secant_code_calibrator_top.sv
// Top level of the secant code calibrator: sequencer and datapath.
//
// Usage: write target_count, tolerance, gain_shift and max_steps through the
// cfg port (cfg_we_i, cfg_idx_i, cfg_data_i) while the block is idle. Send
// command beats on the input channel (in_valid_i / in_stall_o): start loads
// start_code_i, count delivers one counter reading, abort ends with fail.
// Every input beat gives exactly one output beat (out_valid_o / out_stall_i)
// with dac_code_o, apply_o, done_res_o and pass_o.
// A secant step runs the serial divider, which forms one quotient bit per cycle over
// the 48-bit numerator; start, abort, ignored beats, hits and first-form or flat-gain
// steps skip it. One item is in work at a time; in_stall_o stays high until the
// sequencer, after the result enters the output register, returns to its wait step.
// Reset: config takes its reset values, the loop goes idle with pass set,
// no output beat is pending. When the receiver stalls, the output beat holds
// and a further result waits in the sequencer until the register frees.
`default_nettype none

module pll_secant_code_calibrator_top #(
  parameter int CODE_MAX = 2047
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [10:0] start_code_i,
  input  wire logic [15:0] count_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [10:0]      dac_code_o,
  output logic             apply_o,
  output logic             done_res_o,
  output logic             pass_o
);

  pscc_pkg::ucop_e  op;
  pscc_pkg::flags_t flags;

  pscc_useq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .op_o    (op)
  );

  pscc_datapath #(
    .CODE_MAX (CODE_MAX)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .flags_o      (flags),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .start_code_i (start_code_i),
    .count_i      (count_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dac_code_o   (dac_code_o),
    .apply_o      (apply_o),
    .done_res_o   (done_res_o),
    .pass_o       (pass_o)
  );

endmodule

`default_nettype wire

### bench/pll_secant_code_calibrator_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the secant code calibrator: directed table, then random trim loops.
module pll_secant_code_calibrator_top_tb;

  localparam int CodeMax = 2047;
  localparam int FlatGain = 20;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int QuietLimit = 3000;
  localparam int SettleCycles = 100;
  localparam int ItemsPerSetting = 60;
  localparam int NumSettings = 8;
  localparam longint CorrHi = 2147483647;
  localparam longint CorrLo = -CorrHi - 1;

  typedef struct packed {
    logic [10:0] dac_code;
    logic        apply;
    logic        done_res;
    logic        pass;
  } update_t;

  typedef struct {
    logic [1:0]  command;
    logic [10:0] start_code;
    logic [15:0] count;
    bit          typed;
    update_t     update;
  } row_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  command_i;
  logic [10:0] start_code_i;
  logic [15:0] count_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [10:0] dac_code_o;
  logic        apply_o;
  logic        done_res_o;
  logic        pass_o;

  // predictor copy of the registers and loop state
  logic [15:0] target_q;
  logic [7:0]  tol_q;
  logic [3:0]  gain_q;
  logic [7:0]  steps_q;
  logic [10:0] code_q;
  logic [15:0] prev_count_q;
  int          last_corr_q;
  logic [7:0]  step_q;
  bit          first_form_q;
  bit          running_q;
  bit          pass_q;

  update_t     expected_updates[$];
  update_t     seen_update;
  int          mismatches = 0;
  int          beats_sent = 0;
  int          loops_pass = 0;
  int          loops_fail = 0;
  int          burst_left = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  int          stall_tick = 0;
  stall_mode_e stall_mode = STALL_NONE;

  pll_secant_code_calibrator_top #(
    .CODE_MAX(CodeMax)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .start_code_i(start_code_i),
    .count_i     (count_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dac_code_o  (dac_code_o),
    .apply_o     (apply_o),
    .done_res_o  (done_res_o),
    .pass_o      (pass_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void end_loop(input bit ok);
    running_q = 1'b0;
    if (ok) begin
      loops_pass++;
    end else begin
      pass_q = 1'b0;
      loops_fail++;
    end
  endfunction

  function automatic bit trim_step(input logic [15:0] cnt);
    longint err, err_abs, corr, code, diff;
    bit applied;
    applied = 1'b0;
    err = longint'(target_q) - longint'(cnt);
    err_abs = (err < 0) ? -err : err;
    if (err_abs <= longint'(tol_q)) begin
      if (step_q == 8'd0) first_form_q = 1'b1;
      if (step_q >= 8'd1) begin
        end_loop(1'b1);
        return 1'b0;
      end
    end else begin
      if (step_q == 8'd0 || first_form_q) begin
        first_form_q = 1'b0;
        corr = err * (longint'(1) << gain_q);
      end else begin
        diff = longint'(cnt) - longint'(prev_count_q);
        if (diff == 0) corr = err * FlatGain;
        else corr = (err * longint'(last_corr_q)) / diff;
      end
      if (corr > CorrHi) corr = CorrHi;
      else if (corr < CorrLo) corr = CorrLo;
      last_corr_q = int'(corr);
      code = longint'(code_q) + corr;
      if (code >= CodeMax) code = CodeMax;
      else if (code <= 0) code = 0;
      code_q = code[10:0];
      if ((code == CodeMax || code == 0) && step_q >= 8'd1) begin
        end_loop(1'b0);
        return 1'b0;
      end
      prev_count_q = cnt;
      applied = 1'b1;
    end
    step_q = step_q + 8'd1;
    if (step_q >= steps_q || step_q == 8'd0) end_loop(1'b1);
    return applied;
  endfunction

  function automatic update_t calibrate(input logic [1:0] cmd, input logic [10:0] sc,
                                        input logic [15:0] cnt);
    update_t u;
    bit applied;
    applied = 1'b0;
    case (cmd)
      pscc_pkg::CMD_START: begin
        code_q = sc;
        prev_count_q = '0;
        last_corr_q = 0;
        step_q = '0;
        first_form_q = 1'b0;
        running_q = 1'b1;
        pass_q = 1'b1;
        applied = 1'b1;
      end
      pscc_pkg::CMD_COUNT: if (running_q) applied = trim_step(cnt);
      pscc_pkg::CMD_ABORT: if (running_q) end_loop(1'b0);
      default: ;
    endcase
    u = '{code_q, applied, !running_q, pass_q};
    return u;
  endfunction

  function automatic void flag_mismatch(input string what, input update_t want,
                                        input update_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t %s: want code %0d apply %0b done %0b pass %0b, ",
                "got code %0d apply %0b done %0b pass %0b"},
               $time, what, want.dac_code, want.apply, want.done_res, want.pass,
               got.dac_code, got.apply, got.done_res, got.pass);
  endfunction

  function automatic row_t step_row(input logic [1:0] cmd, input logic [10:0] sc,
                                    input logic [15:0] cnt, input bit typed,
                                    input logic [10:0] dac, input bit ap, input bit dn,
                                    input bit ps);
    row_t r;
    r.command = cmd;
    r.start_code = sc;
    r.count = cnt;
    r.typed = typed;
    r.update = '{dac, ap, dn, ps};
    return r;
  endfunction

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_beat(input logic [1:0] cmd, input logic [10:0] sc,
                           input logic [15:0] cnt, input bit typed, input update_t typed_update);
    update_t predicted;
    in_valid_i <= 1'b1;
    command_i <= cmd;
    start_code_i <= sc;
    count_i <= cnt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = calibrate(cmd, sc, cnt);
    expected_updates.push_back(typed ? typed_update : predicted);
    beats_sent++;
    pace_sender();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_settings(input logic [15:0] t, input logic [7:0] tol,
                                  input logic [3:0] g, input logic [7:0] m);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= pscc_pkg::REG_TARGET;
    cfg_data_i <= t;
    @(posedge clk_i);
    cfg_idx_i <= pscc_pkg::REG_TOLERANCE;
    cfg_data_i <= {8'($urandom), tol};
    @(posedge clk_i);
    cfg_idx_i <= pscc_pkg::REG_GAIN;
    cfg_data_i <= {12'($urandom), g};
    @(posedge clk_i);
    cfg_idx_i <= pscc_pkg::REG_MAX_STEPS;
    cfg_data_i <= {8'($urandom), m};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    target_q = t;
    tol_q = tol;
    gain_q = g;
    steps_q = m;
  endtask

  // one trim loop against a linear oscillator with noise, plus stray beats
  task automatic trim_session(output int counted);
    int center, slope, noise, act;
    longint sample;
    logic [10:0] sc;
    counted = 0;
    center = $urandom_range(0, CodeMax);
    slope = $urandom_range(1, 6);
    if ($urandom_range(0, 9) == 0) sc = $urandom_range(0, 1) ? 11'(CodeMax) : 11'd0;
    else sc = 11'($urandom);
    send_beat(pscc_pkg::CMD_START, sc, 16'($urandom), 1'b0, '0);
    counted++;
    while (running_q && counted < 48) begin
      act = $urandom_range(0, 99);
      noise = int'($urandom_range(0, 6)) - 3;
      sample = longint'(target_q) + (longint'(code_q) - center) * slope + noise;
      if (sample < 0) sample = 0;
      else if (sample > 65535) sample = 65535;
      if (act < 78) begin
        send_beat(pscc_pkg::CMD_COUNT, 11'($urandom), sample[15:0], 1'b0, '0);
        counted++;
      end else if (act < 88) begin
        send_beat(pscc_pkg::CMD_COUNT, 11'($urandom), 16'($urandom), 1'b0, '0);
        counted++;
      end else if (act < 92) begin
        send_beat(pscc_pkg::CMD_ABORT, 11'($urandom), 16'($urandom), 1'b0, '0);
        counted++;
      end else if (act < 96) begin
        send_beat(CMD_SPARE, 11'($urandom), 16'($urandom), 1'b0, '0);
      end else begin
        send_beat(pscc_pkg::CMD_START, 11'($urandom), 16'($urandom), 1'b0, '0);
        counted++;
      end
    end
    if ($urandom_range(0, 3) == 0)
      send_beat(2'($urandom_range(1, 3)), 11'($urandom), 16'($urandom), 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_update = '{dac_code_o, apply_o, done_res_o, pass_o};
      if (expected_updates.size() == 0) begin
        flag_mismatch("unexpected beat", '0, seen_update);
      end else begin
        if (seen_update.dac_code !== expected_updates[0].dac_code ||
            seen_update.apply !== expected_updates[0].apply ||
            seen_update.done_res !== expected_updates[0].done_res ||
            seen_update.pass !== expected_updates[0].pass)
          flag_mismatch("wrong result", expected_updates[0], seen_update);
        void'(expected_updates.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 120);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ((stall_tick % 8) < 3);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("watchdog: %0d cycles without a beat", quiet_cycles);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    row_t rows[$];
    int counted, setting_items;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    command_i = '0;
    start_code_i = '0;
    count_i = '0;
    out_stall_i = 1'b0;
    target_q = 16'd0;
    tol_q = 8'd1;
    gain_q = 4'd5;
    steps_q = 8'd2;
    code_q = '0;
    prev_count_q = '0;
    last_corr_q = 0;
    step_q = '0;
    first_form_q = 1'b0;
    running_q = 1'b0;
    pass_q = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows.push_back(step_row(pscc_pkg::CMD_COUNT, 11'd0, 16'd1234, 1'b1, 11'd0, 1'b0, 1'b1, 1'b1));
    rows.push_back(step_row(pscc_pkg::CMD_ABORT, 11'd0, 16'd0, 1'b1, 11'd0, 1'b0, 1'b1, 1'b1));
    rows.push_back(step_row(CMD_SPARE, 11'd2047, 16'd65535, 1'b1, 11'd0, 1'b0, 1'b1, 1'b1));
    rows.push_back(step_row(pscc_pkg::CMD_START, 11'd2047, 16'd0, 1'b1, 11'd2047, 1'b1, 1'b0,
                            1'b1));
    rows.push_back(step_row(pscc_pkg::CMD_COUNT, 11'd0, 16'd0, 1'b1, 11'd2047, 1'b0, 1'b0, 1'b1));
    rows.push_back(step_row(pscc_pkg::CMD_COUNT, 11'd0, 16'd65535, 1'b1, 11'd0, 1'b0, 1'b1,
                            1'b0));
    rows.push_back(step_row(pscc_pkg::CMD_START, 11'd0, 16'd0, 1'b1, 11'd0, 1'b1, 1'b0, 1'b1));
    rows.push_back(step_row(CMD_SPARE, 11'd0, 16'd0, 1'b1, 11'd0, 1'b0, 1'b0, 1'b1));
    rows.push_back(step_row(pscc_pkg::CMD_ABORT, 11'd0, 16'd0, 1'b1, 11'd0, 1'b0, 1'b1, 1'b0));
    rows.push_back(step_row(pscc_pkg::CMD_START, 11'd1000, 16'd0, 1'b1, 11'd1000, 1'b1, 1'b0,
                            1'b1));
    rows.push_back(step_row(pscc_pkg::CMD_COUNT, 11'd0, 16'd65535, 1'b0, '0, 1'b0, 1'b0, 1'b0));
    rows.push_back(step_row(pscc_pkg::CMD_COUNT, 11'd0, 16'd3, 1'b0, '0, 1'b0, 1'b0, 1'b0));
    rows.push_back(step_row(pscc_pkg::CMD_START, 11'd1000, 16'd0, 1'b1, 11'd1000, 1'b1, 1'b0,
                            1'b1));
    rows.push_back(step_row(pscc_pkg::CMD_COUNT, 11'd0, 16'd10, 1'b0, '0, 1'b0, 1'b0, 1'b0));
    rows.push_back(step_row(pscc_pkg::CMD_COUNT, 11'd0, 16'd10, 1'b0, '0, 1'b0, 1'b0, 1'b0));
    rows.push_back(step_row(pscc_pkg::CMD_START, 11'd1500, 16'd0, 1'b1, 11'd1500, 1'b1, 1'b0,
                            1'b1));
    rows.push_back(step_row(pscc_pkg::CMD_START, 11'd700, 16'd0, 1'b1, 11'd700, 1'b1, 1'b0,
                            1'b1));
    rows.push_back(step_row(pscc_pkg::CMD_COUNT, 11'd0, 16'd100, 1'b0, '0, 1'b0, 1'b0, 1'b0));
    rows.push_back(step_row(pscc_pkg::CMD_COUNT, 11'd0, 16'd1, 1'b0, '0, 1'b0, 1'b0, 1'b0));
    rows.push_back(step_row(pscc_pkg::CMD_START, 11'd1024, 16'd0, 1'b1, 11'd1024, 1'b1, 1'b0,
                            1'b1));
    rows.push_back(step_row(pscc_pkg::CMD_COUNT, 11'd0, 16'd8, 1'b0, '0, 1'b0, 1'b0, 1'b0));
    rows.push_back(step_row(pscc_pkg::CMD_COUNT, 11'd0, 16'd4, 1'b0, '0, 1'b0, 1'b0, 1'b0));
    rows.push_back(step_row(pscc_pkg::CMD_COUNT, 11'd0, 16'd4, 1'b0, '0, 1'b0, 1'b0, 1'b0));
    foreach (rows[i])
      send_beat(rows[i].command, rows[i].start_code, rows[i].count, rows[i].typed,
                rows[i].update);

    for (int s = 0; s < NumSettings; s++) begin
      drain();
      case (s)
        0: program_settings(16'd1000, 8'd0, 4'd0, 8'd1);
        1: program_settings(16'd65535, 8'd255, 4'd15, 8'd255);
        2: program_settings(16'd0, 8'd255, 4'd15, 8'd1);
        3: program_settings(16'd30000, 8'd4, 4'd3, 8'd16);
        default: program_settings(16'($urandom_range(2000, 63000)), 8'($urandom_range(0, 8)),
                                  4'($urandom_range(0, 6)),
                                  ($urandom_range(0, 3) == 0) ? 8'd255
                                                              : 8'($urandom_range(2, 40)));
      endcase
      setting_items = 0;
      while (setting_items < ItemsPerSetting) begin
        trim_session(counted);
        setting_items += counted;
      end
    end
    drain();

    $display("Run covered %0d command beats under reset values and %0d register settings.",
             beats_sent, NumSettings);
    $display("Trim loops ended: %0d pass, %0d fail; %0d result checks failed.",
             loops_pass, loops_fail, mismatches);
    if (mismatches == 0 && expected_updates.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
